[rtl/tpsd_pkg.sv]
// shared types, codes and the crc step of the text packet stream deframer
package tpsd_pkg;

    localparam int TPSD_NUM_CHANNELS = 128;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd254;
    localparam logic [7:0]  BYTE_MAX      = 8'hFF;

    localparam logic [1:0] OP_RX  = 2'd0;
    localparam logic [1:0] OP_ARM = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_OK      = 3'd2;
    localparam logic [2:0] KIND_BAD     = 3'd3;
    localparam logic [2:0] KIND_ABORT   = 3'd4;

    typedef enum logic [3:0] {
        MODE_TEXT    = 4'b0001,
        MODE_COBS    = 4'b0010,
        MODE_DATA    = 4'b0100,
        MODE_DISCARD = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_value;
        logic [6:0] arm_channel;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  byte_out;
        logic [6:0]  chan_out;
        logic [31:0] errors_out;
    } t_result;

    typedef struct packed {
        logic       en;
        logic [6:0] addr;
        logic       data;
    } t_arm_wr;

    // one byte of crc-16-ccitt, msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/tpsd_stream_if.sv]
// valid/ready stream interfaces for input items and result items
interface tpsd_in_if import tpsd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_value;
    logic [6:0] arm_channel;

    modport source (output valid, output opcode, output rx_value, output arm_channel,
                    input ready);
    modport sink   (input valid, input opcode, input rx_value, input arm_channel,
                    output ready);
endinterface

interface tpsd_out_if import tpsd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic [6:0]  chan_out;
    logic [31:0] errors_out;

    modport source (output valid, output kind, output byte_out, output chan_out,
                    output errors_out, input ready);
    modport sink   (input valid, input kind, input byte_out, input chan_out,
                    input errors_out, output ready);
endinterface

[rtl/text_packet_stream_deframer_unit.sv]
// Text/packet stream deframer: splits a received byte stream into text and cobs packets.
// Input channel i_in (valid/ready) carries one opcode per transfer: a received byte,
// a channel arm, or an error count clear. Output channel o_out (valid/ready) carries
// zero or one result per input transfer: a text char, a payload byte, or a packet
// verdict (ok, bad crc or short, aborted) with the current error count.
// Configuration: i_cfg_we writes i_cfg_wdata into the max encoded length register;
// write only while the block is idle.
// Throughput: one input transfer per cycle unless o_out stalls or a clearing pass runs.
// The armed-channel table is a ram with a registered read, read at accept, written back
// when the work stage fires; a forwarding register covers a write made during a read.
// Path: an input transfer is registered in the work stage, and its result in the output
// register that drives o_out, which holds it until taken.
// Reset (synchronous, active low): the control state clears, then a clearing pass over
// all NUM_CHANNELS entries disarms every channel; i_in.ready stays low for that pass.
// Stalls: the output register holds a result until taken; while it is full and not
// taken, the work stage holds its item and i_in.ready drops, so nothing is lost.
module text_packet_stream_deframer_unit import tpsd_pkg::*; #(
    parameter int NUM_CHANNELS = TPSD_NUM_CHANNELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpsd_in_if.sink    i_in,
    tpsd_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);
    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic             accept;
    logic             s1_fire;
    logic             r_s1_v;
    t_item            r_s1_item;
    logic             r_clr_busy;
    logic [CH_AW-1:0] r_clr_idx;
    logic             r_fwd_v;
    logic [CH_AW-1:0] r_fwd_addr;
    logic             r_fwd_data;
    logic             ram_we;
    logic [CH_AW-1:0] ram_waddr;
    logic             ram_wdata;
    logic             ram_rdata;
    logic [CH_AW-1:0] s1_addr;
    logic             armed;
    t_result          core_res;
    t_arm_wr          core_wr;
    logic             r_o_v;
    t_result          r_o;

    assign s1_fire    = r_s1_v && (!r_o_v || o_out.ready);
    assign i_in.ready = !r_clr_busy && (!r_s1_v || s1_fire);
    assign accept     = i_in.valid && i_in.ready;

    assign s1_addr = r_s1_item.rx_value[CH_AW-1:0];
    assign armed   = (r_fwd_v && (r_fwd_addr == s1_addr)) ? r_fwd_data : ram_rdata;

    assign ram_we    = r_clr_busy || core_wr.en;
    assign ram_waddr = r_clr_busy ? r_clr_idx : core_wr.addr[CH_AW-1:0];
    assign ram_wdata = r_clr_busy ? 1'b0 : core_wr.data;

    tpsd_ram #(
        .WIDTH (1),
        .DEPTH (NUM_CHANNELS),
        .AW    (CH_AW)
    ) u_arm_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_in.rx_value[CH_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    tpsd_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_item      (r_s1_item),
        .i_armed     (armed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (core_res),
        .o_wr        (core_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_fwd_v    <= 1'b0;
            r_o_v      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (r_clr_busy) begin
                if (r_clr_idx == CH_AW'(NUM_CHANNELS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + CH_AW'(1);
                end
            end
            if (accept) begin
                r_fwd_v <= core_wr.en;
            end
            if (s1_fire) begin
                r_o_v <= core_res.valid;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.opcode      <= i_in.opcode;
            r_s1_item.rx_value    <= i_in.rx_value;
            r_s1_item.arm_channel <= i_in.arm_channel;
            r_fwd_addr            <= core_wr.addr[CH_AW-1:0];
            r_fwd_data            <= core_wr.data;
        end
        if (s1_fire) begin
            r_o <= core_res;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.kind       = r_o.kind;
    assign o_out.byte_out   = r_o.byte_out;
    assign o_out.chan_out   = r_o.chan_out;
    assign o_out.errors_out = r_o.errors_out;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("input accepted during clearing pass");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_wr.en |-> (s1_fire && !r_clr_busy))
        else $error("arm table write outside a work stage transfer");

    a_stage_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_v)
        else $error("accepted item missing from work stage");
`endif
endmodule

[rtl/tpsd_ram.sv]
// generic single-port-write, registered-read ram
module tpsd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/tpsd_core.sv]
// per-byte deframing state: cobs decode, crc, hold line and error count
module tpsd_core import tpsd_pkg::*; #(
    parameter int NUM_CHANNELS = TPSD_NUM_CHANNELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_item     i_item,
    input  logic      i_armed,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output t_result   o_res,
    output t_arm_wr   o_wr
);
    t_mode       r_mode, n_mode;
    logic [6:0]  r_cur, n_cur;
    logic [7:0]  r_cd, n_cd;
    logic [7:0]  r_bc, n_bc;
    logic [7:0]  r_disc, n_disc;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_h0, n_h0;
    logic [7:0]  r_h1, n_h1;
    logic [1:0]  r_hc, n_hc;
    logic [31:0] r_err, n_err;
    logic [7:0]  r_max_len;

    logic [7:0] b;
    logic [7:0] cd_dec;
    logic [7:0] dec;
    logic       hdr_ok;
    logic       arm_ok;
    logic       good;

    assign b      = i_item.rx_value;
    assign cd_dec = r_cd - 8'd1;
    assign dec    = (cd_dec == 8'd0) ? 8'd0 : b;
    assign hdr_ok = (8'(b[6:0]) < 8'(NUM_CHANNELS)) && i_armed;
    assign arm_ok = 8'(i_item.arm_channel) < 8'(NUM_CHANNELS);
    assign good   = r_hc[1] && ({r_h1, r_h0} == r_crc);

    always_comb begin
        n_mode = r_mode;
        n_cur  = r_cur;
        n_cd   = r_cd;
        n_bc   = r_bc;
        n_disc = r_disc;
        n_crc  = r_crc;
        n_h0   = r_h0;
        n_h1   = r_h1;
        n_hc   = r_hc;
        n_err  = r_err;
        o_res  = '0;
        o_wr   = '0;
        if (i_fire) begin
            case (i_item.opcode)
                OP_ARM: begin
                    o_wr.en   = arm_ok;
                    o_wr.addr = i_item.arm_channel;
                    o_wr.data = 1'b1;
                end
                OP_CLR: begin
                    n_err = '0;
                end
                OP_RX: begin
                    unique case (r_mode)
                        MODE_TEXT: begin
                            if (b[7]) begin
                                if (hdr_ok) begin
                                    n_cur  = b[6:0];
                                    n_bc   = '0;
                                    n_hc   = '0;
                                    n_crc  = {b, ~b};
                                    n_mode = MODE_COBS;
                                end else begin
                                    n_err  = r_err + 32'd1;
                                    n_disc = '0;
                                    n_mode = MODE_DISCARD;
                                end
                            end else if (b != 8'd0) begin
                                o_res.valid    = 1'b1;
                                o_res.kind     = KIND_TEXT;
                                o_res.byte_out = b;
                            end
                        end
                        MODE_DISCARD: begin
                            if (b == 8'd0) begin
                                n_mode = MODE_TEXT;
                            end else begin
                                if (r_disc != BYTE_MAX) begin
                                    n_disc = r_disc + 8'd1;
                                end
                                if (n_disc == BYTE_MAX) begin
                                    n_mode = MODE_TEXT;
                                end
                            end
                        end
                        MODE_COBS: begin
                            if (b == 8'd0) begin
                                n_err          = r_err + 32'd1;
                                n_mode         = MODE_TEXT;
                                o_res.valid    = 1'b1;
                                o_res.kind     = KIND_ABORT;
                                o_res.chan_out = r_cur;
                            end else begin
                                n_cd   = b;
                                n_mode = MODE_DATA;
                            end
                        end
                        MODE_DATA: begin
                            if (b == 8'd0) begin
                                o_wr.en        = 1'b1;
                                o_wr.addr      = r_cur;
                                o_wr.data      = 1'b0;
                                n_mode         = MODE_TEXT;
                                o_res.valid    = 1'b1;
                                o_res.chan_out = r_cur;
                                if (good) begin
                                    o_res.kind = KIND_OK;
                                end else begin
                                    n_err      = r_err + 32'd1;
                                    o_res.kind = KIND_BAD;
                                end
                            end else if (r_bc >= r_max_len) begin
                                n_err          = r_err + 32'd1;
                                n_disc         = (r_bc != BYTE_MAX) ? r_bc + 8'd1 : BYTE_MAX;
                                n_mode         = MODE_DISCARD;
                                o_res.valid    = 1'b1;
                                o_res.kind     = KIND_ABORT;
                                o_res.chan_out = r_cur;
                            end else begin
                                n_cd = (cd_dec == 8'd0) ? b : cd_dec;
                                n_bc = r_bc + 8'd1;
                                if (!r_hc[1]) begin
                                    if (r_hc[0]) begin
                                        n_h1 = dec;
                                    end else begin
                                        n_h0 = dec;
                                    end
                                    n_hc = r_hc + 2'd1;
                                end else begin
                                    n_crc          = crc16_step(r_crc, r_h0);
                                    n_h0           = r_h1;
                                    n_h1           = dec;
                                    o_res.valid    = 1'b1;
                                    o_res.kind     = KIND_PAYLOAD;
                                    o_res.byte_out = r_h0;
                                    o_res.chan_out = r_cur;
                                end
                            end
                        end
                        default: begin
                            n_mode = MODE_TEXT;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        o_res.errors_out = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TEXT;
            r_cur     <= '0;
            r_cd      <= '0;
            r_bc      <= '0;
            r_disc    <= '0;
            r_crc     <= '0;
            r_hc      <= '0;
            r_err     <= '0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            r_mode <= n_mode;
            r_cur  <= n_cur;
            r_cd   <= n_cd;
            r_bc   <= n_bc;
            r_disc <= n_disc;
            r_crc  <= n_crc;
            r_hc   <= n_hc;
            r_err  <= n_err;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    // hold line needs no reset, the fill count guards every read
    always_ff @(posedge i_clk) begin
        r_h0 <= n_h0;
        r_h1 <= n_h1;
    end
endmodule
